// ----- hw/rtl/wfc_pkg.sv -----
// Package for the weigh fill controller: shared types, codes and fixed constants.
// Used by wfc_ctrl, weigh_fill_controller and the testbench; depends on nothing else.
package wfc_pkg;

    // Width of the threshold registers and of the reported readings.
    localparam int REG_W      = 25;
    localparam int MODE_W     = 2;
    localparam int DEB_W      = 16;
    localparam int NUM_THR    = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int M_TDATA_W  = 56;

    // Debounce history: upper bits forced high, one press is the pattern below.
    localparam logic [DEB_W-1:0] DEB_FORCE = 16'hE000;
    localparam logic [DEB_W-1:0] DEB_PRESS = 16'hF000;

    // Mode codes.
    localparam logic [MODE_W-1:0] MODE_0      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_1      = 2'd1;
    localparam logic [MODE_W-1:0] MODE_2      = 2'd2;
    localparam logic [MODE_W-1:0] MODE_MANUAL = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_THR_MODE0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_MODE1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_MODE2 = 2'd2;

    typedef logic signed [REG_W-1:0] thr_t;

    // Threshold reset values.
    localparam thr_t THR_RESET_MODE0 = 25'sd220000;
    localparam thr_t THR_RESET_MODE1 = 25'sd240000;
    localparam thr_t THR_RESET_MODE2 = 25'sd250000;

    // Threshold of the manual mode.
    localparam thr_t THR_MANUAL = '1;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_AUTO   = 2'd1,
        PH_MANUAL = 2'd2
    } phase_t;

    // One result item, relay_on in the lowest bit.
    typedef struct packed {
        logic signed [REG_W-1:0] last_median;
        logic signed [REG_W-1:0] net_reading;
        logic                    fill_done;
        logic [MODE_W-1:0]       current_mode;
        logic                    relay_on;
    } result_t;

endpackage

// ----- hw/rtl/wfc_median.sv -----
// Median selector for one group of readings, built from parallel rank counts.
// Depends on nothing but its parameters.
module wfc_median #(
    parameter int N = 3,
    parameter int W = 25
) (
    input  logic signed [W-1:0] vals [N],
    output logic signed [W-1:0] med
);
    localparam int RANK_W = $clog2(N) + 1;
    localparam int MID    = (N - 1) / 2;

    logic [RANK_W-1:0] rank [N];

    // Each value's rank counts the values below it; equal values are ordered
    // by position so that every rank appears exactly once.
    always_comb begin
        for (int i = 0; i < N; i++) begin
            rank[i] = '0;
            for (int j = 0; j < N; j++) begin
                if (j != i) begin
                    if ((vals[j] < vals[i]) || ((vals[j] == vals[i]) && (j < i))) begin
                        rank[i] = rank[i] + RANK_W'(1);
                    end
                end
            end
        end
    end

    always_comb begin
        med = '0;
        for (int i = 0; i < N; i++) begin
            if (rank[i] == RANK_W'(MID)) begin
                med = med | vals[i];
            end
        end
    end

endmodule

// ----- hw/rtl/wfc_ctrl.sv -----
// Fill control state: debounce, mode, fill phase, group store and median hold.
// Depends on wfc_pkg and wfc_median.
module wfc_ctrl #(
    parameter int GROUP_SIZE  = 3,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  logic signed [SAMPLE_BITS-1:0] raw_sample,
    input  logic                          dispense_level,
    input  logic                          mode_level,
    input  wfc_pkg::thr_t                 thresholds [wfc_pkg::NUM_THR],
    output wfc_pkg::result_t              result
);
    import wfc_pkg::*;

    localparam int NET_W       = SAMPLE_BITS + 1;
    localparam int CMP_W       = (NET_W > REG_W) ? NET_W : REG_W;
    localparam int STORE_DEPTH = (GROUP_SIZE > 1) ? GROUP_SIZE - 1 : 1;
    localparam int CNT_W       = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;
    localparam int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(GROUP_SIZE - 1);

    logic [DEB_W-1:0]        deb_reg, deb_next;
    logic [MODE_W-1:0]       mode_reg, mode_next;
    phase_t                  phase_reg, phase_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic                    pending_reg, pending_next;
    logic signed [CMP_W-1:0] median_reg, median_next;
    logic signed [CMP_W-1:0] store_reg [STORE_DEPTH];

    logic signed [CMP_W-1:0] net;
    logic signed [CMP_W-1:0] thr_cur;
    logic signed [CMP_W-1:0] group_vals [GROUP_SIZE];
    logic signed [CMP_W-1:0] group_med;
    thr_t                    thr_sel;
    logic                    store_we;
    logic                    press;
    logic                    relay;
    logic                    done;

    assign net = -CMP_W'(raw_sample);

    always_comb begin
        unique case (mode_reg)
            MODE_0:      thr_sel = thresholds[0];
            MODE_1:      thr_sel = thresholds[1];
            MODE_2:      thr_sel = thresholds[2];
            MODE_MANUAL: thr_sel = THR_MANUAL;
            default:     thr_sel = THR_MANUAL;
        endcase
    end

    assign thr_cur = CMP_W'(thr_sel);

    // The last value of a group is the reading of this item.
    always_comb begin
        for (int i = 0; i < GROUP_SIZE - 1; i++) begin
            group_vals[i] = store_reg[i];
        end
        group_vals[GROUP_SIZE-1] = net;
    end

    wfc_median #(
        .N (GROUP_SIZE),
        .W (CMP_W)
    ) u_median (
        .vals (group_vals),
        .med  (group_med)
    );

    always_comb begin
        deb_next     = deb_reg;
        mode_next    = mode_reg;
        phase_next   = phase_reg;
        count_next   = count_reg;
        pending_next = pending_reg;
        median_next  = median_reg;
        store_we     = 1'b0;
        press        = 1'b0;
        relay        = 1'b0;
        done         = 1'b0;

        unique case (phase_reg)
            PH_AUTO: begin
                relay = 1'b1;
                if (count_reg != CNT_LAST) begin
                    store_we   = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end else begin
                    median_next = group_med;
                    count_next  = '0;
                    if (group_med >= thr_cur) begin
                        relay      = 1'b0;
                        done       = 1'b1;
                        phase_next = PH_IDLE;
                        if (pending_reg) begin
                            mode_next    = mode_reg + MODE_W'(1);
                            pending_next = 1'b0;
                        end
                    end
                end
            end
            PH_MANUAL: begin
                relay = 1'b1;
                if (dispense_level) begin
                    relay      = 1'b0;
                    done       = 1'b1;
                    phase_next = PH_IDLE;
                    count_next = '0;
                    if (pending_reg) begin
                        mode_next    = mode_reg + MODE_W'(1);
                        pending_next = 1'b0;
                    end
                end
            end
            default: begin
                // Idle, and any code that is not a fill phase.
                phase_next = PH_IDLE;
                deb_next   = {deb_reg[DEB_W-2:0], ~mode_level} | DEB_FORCE;
                press      = (deb_next == DEB_PRESS);
                if (!dispense_level && (net < thr_cur)) begin
                    relay      = 1'b1;
                    count_next = '0;
                    phase_next = (mode_reg == MODE_MANUAL) ? PH_MANUAL : PH_AUTO;
                    if (press) begin
                        pending_next = 1'b1;
                    end
                end else if (press) begin
                    mode_next = mode_reg + MODE_W'(1);
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deb_reg     <= '0;
            mode_reg    <= MODE_0;
            phase_reg   <= PH_IDLE;
            count_reg   <= '0;
            pending_reg <= 1'b0;
            median_reg  <= '0;
        end else if (step) begin
            deb_reg     <= deb_next;
            mode_reg    <= mode_next;
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            pending_reg <= pending_next;
            median_reg  <= median_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && store_we) begin
            store_reg[count_reg[IDX_W-1:0]] <= net;
        end
    end

    always_comb begin
        result.relay_on     = relay;
        result.current_mode = mode_next;
        result.fill_done    = done;
        result.net_reading  = net[REG_W-1:0];
        result.last_median  = median_next[REG_W-1:0];
    end

    // A finished fill leaves the block idle with no press held back.
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        step && result.fill_done |=> (phase_reg == PH_IDLE) && !pending_reg)
        else $error("fill end did not return to idle");

    // A held-back press exists only while a fill runs.
    a_pending_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg |-> (phase_reg == PH_AUTO) || (phase_reg == PH_MANUAL))
        else $error("pending press outside a fill");

    // An automatic fill that keeps the relay on stays an automatic fill.
    a_auto_stays: assert property (@(posedge aclk) disable iff (!aresetn)
        step && (phase_reg == PH_AUTO) && result.relay_on |=> phase_reg == PH_AUTO)
        else $error("automatic fill left while relay on");

    // Without an item the mode and debounce history do not move.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !step |=> $stable(mode_reg) && $stable(deb_reg))
        else $error("state changed without an item");

endmodule

// ----- hw/rtl/weigh_fill_controller.sv -----
// Weigh fill controller, top level. An item accepted into the input register
// goes through wfc_ctrl to the result register that drives m_tdata and m_tvalid.
// Throughput: one item per cycle while m_tready is high; the input register and
// the result register both advance in the same cycle, so the stream never stalls on its own.
// Reset (aresetn low at a clock edge) empties both registers, restores the three
// thresholds and clears debounce, mode, fill phase, group count and median.
// Depends on wfc_pkg and wfc_ctrl.
module weigh_fill_controller #(
    parameter int GROUP_SIZE  = 3,
    parameter int SAMPLE_BITS = 24,
    localparam int S_TDATA_W  = ((SAMPLE_BITS + 2 + 7) / 8) * 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Input items.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // Fields from bit 0: raw_sample, dispense_level, mode_level, zero padding.
    input  logic [S_TDATA_W-1:0]               s_tdata,
    // Result items.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // Fields from bit 0: relay_on, current_mode, fill_done, net_reading,
    // last_median, zero padding.
    output logic [wfc_pkg::M_TDATA_W-1:0]      m_tdata,
    // Threshold register writes.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [wfc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wfc_pkg::REG_W-1:0]          cfg_data
);
    import wfc_pkg::*;

    localparam int RES_W = $bits(result_t);

    // Input register: holds one accepted item until it is worked on.
    logic                          in_valid_reg;
    logic signed [SAMPLE_BITS-1:0] raw_reg;
    logic                          disp_reg;
    logic                          mode_lvl_reg;

    // Result register.
    logic                          out_valid_reg;
    logic [M_TDATA_W-1:0]          out_data_reg;

    thr_t                          thr_reg [NUM_THR];
    result_t                       result;
    logic                          advance;

    // The item in the input register moves on whenever the result register is
    // empty or is being emptied this cycle; that is also the state update.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Threshold writes are always taken; an index beyond the list is dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg[0] <= THR_RESET_MODE0;
            thr_reg[1] <= THR_RESET_MODE1;
            thr_reg[2] <= THR_RESET_MODE2;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_THR_MODE0: thr_reg[0] <= cfg_data;
                CFG_THR_MODE1: thr_reg[1] <= cfg_data;
                CFG_THR_MODE2: thr_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            raw_reg      <= s_tdata[SAMPLE_BITS-1:0];
            disp_reg     <= s_tdata[SAMPLE_BITS];
            mode_lvl_reg <= s_tdata[SAMPLE_BITS+1];
        end
    end

    wfc_ctrl #(
        .GROUP_SIZE  (GROUP_SIZE),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step           (advance),
        .raw_sample     (raw_reg),
        .dispense_level (disp_reg),
        .mode_level     (mode_lvl_reg),
        .thresholds     (thr_reg),
        .result         (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {{(M_TDATA_W - RES_W){1'b0}}, result};
        end
    end

endmodule

// ----- dv/tb_weigh_fill_controller.sv -----
// Self-checking testbench for weigh_fill_controller: random tick traffic with
// stream gaps and result stalls, checked against a cycle-free behavioral predictor.
// Depends on wfc_pkg and the weigh_fill_controller RTL only.
module tb_weigh_fill_controller;
    timeunit 1ns;
    timeprecision 1ps;
    import wfc_pkg::*;

    localparam int SAMPLE_W = 24;
    localparam int S_W      = ((SAMPLE_W + 2 + 7) / 8) * 8;
    localparam int NET_MAX  = 8388608;
    localparam int NET_MIN  = -8388607;
    localparam int TICKS_PER_PHASE = 150;
    localparam int PHASES   = 5;
    localparam int GROUP_N  = 3;

    // Button pins are active low.
    localparam logic PRESSED  = 1'b0;
    localparam logic RELEASED = 1'b1;

    // Index past the register list; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // One input item, raw sample in the lowest bits.
    typedef struct packed {
        logic                mode_lvl;
        logic                disp_lvl;
        logic [SAMPLE_W-1:0] raw;
    } tick_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_W-1:0]       s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_THR_MODE0;
    logic [REG_W-1:0]     cfg_data  = '0;

    weigh_fill_controller dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    tick_t       tick_feed[$];
    result_t     due_results[$];
    int unsigned mismatch_count = 0;

    // Predictor state: thresholds as written, debounce, mode and fill progress.
    thr_t             thr_reg[NUM_THR] = '{THR_RESET_MODE0, THR_RESET_MODE1, THR_RESET_MODE2};
    logic [DEB_W-1:0] deb_hist    = '0;
    logic [MODE_W-1:0] mode_sel   = MODE_0;
    phase_t           fill_state  = PH_IDLE;
    thr_t             grp_buf[GROUP_N-1];
    int               grp_fill    = 0;
    logic             press_held  = 1'b0;
    thr_t             median_hold = '0;

    // A fill ends: back to idle, and a press seen on the start tick takes effect.
    function automatic void close_fill();
        fill_state = PH_IDLE;
        grp_fill   = 0;
        if (press_held) begin
            mode_sel   = mode_sel + 1'b1;
            press_held = 1'b0;
        end
    endfunction

    // Advances the predictor by one tick and returns the result it must produce.
    function automatic result_t next_fill_result(tick_t t);
        result_t r;
        thr_t    net, thr, lo, hi;
        logic    disp_on, mode_on, press;
        net     = -{t.raw[SAMPLE_W-1], t.raw};
        thr     = (mode_sel == MODE_MANUAL) ? THR_MANUAL : thr_reg[mode_sel];
        disp_on = (t.disp_lvl == PRESSED);
        mode_on = (t.mode_lvl == PRESSED);
        r       = '0;
        case (fill_state)
            PH_AUTO: begin
                r.relay_on = 1'b1;
                if (grp_fill < GROUP_N - 1) begin
                    grp_buf[grp_fill] = net;
                    grp_fill++;
                end else begin
                    // Median of three: clamp the newest value between the other two.
                    lo = (grp_buf[0] < grp_buf[1]) ? grp_buf[0] : grp_buf[1];
                    hi = (grp_buf[0] < grp_buf[1]) ? grp_buf[1] : grp_buf[0];
                    median_hold = (net < lo) ? lo : ((net > hi) ? hi : net);
                    grp_fill = 0;
                    if (median_hold >= thr) begin
                        r.relay_on  = 1'b0;
                        r.fill_done = 1'b1;
                        close_fill();
                    end
                end
            end
            PH_MANUAL: begin
                r.relay_on = 1'b1;
                if (!disp_on) begin
                    r.relay_on  = 1'b0;
                    r.fill_done = 1'b1;
                    close_fill();
                end
            end
            default: begin
                fill_state = PH_IDLE;
                deb_hist   = (deb_hist << 1) | {{(DEB_W-1){1'b0}}, mode_on} | DEB_FORCE;
                press      = (deb_hist == DEB_PRESS);
                if (disp_on && net < thr) begin
                    r.relay_on = 1'b1;
                    grp_fill   = 0;
                    fill_state = (mode_sel == MODE_MANUAL) ? PH_MANUAL : PH_AUTO;
                    if (press) press_held = 1'b1;
                end else if (press) begin
                    mode_sel = mode_sel + 1'b1;
                end
            end
        endcase
        r.current_mode = mode_sel;
        r.net_reading  = net;
        r.last_median  = median_hold;
        return r;
    endfunction

    // Sender: bursts of random length separated by random gaps, with the odd
    // long burst so that back-to-back items are also exercised.
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                due_results.push_back(next_fill_result(tick_t'(s_tdata[$bits(tick_t)-1:0])));
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (tick_feed.size() != 0) begin
                    s_tdata  <= S_W'(tick_feed.pop_front());
                    s_tvalid <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        gap_left   = $urandom_range(0, 4);
                        burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
                                                                : $urandom_range(1, 12);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic report_field(input string name, input longint want, input longint got);
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        mismatch_count++;
    endtask

    // Receiver: alternates short stalls with ready runs, some of them long.
    int ready_run = 0;

    always @(posedge aclk) begin
        result_t got, want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata[$bits(result_t)-1:0]);
                if (due_results.size() == 0) begin
                    $display("%0t ns: result with no expectation waiting, actual %h",
                             $time, m_tdata);
                    mismatch_count++;
                end else begin
                    want = due_results.pop_front();
                    if (got.relay_on !== want.relay_on)
                        report_field("relay_on", want.relay_on, got.relay_on);
                    if (got.current_mode !== want.current_mode)
                        report_field("current_mode", want.current_mode, got.current_mode);
                    if (got.fill_done !== want.fill_done)
                        report_field("fill_done", want.fill_done, got.fill_done);
                    if (got.net_reading !== want.net_reading)
                        report_field("net_reading", want.net_reading, got.net_reading);
                    if (got.last_median !== want.last_median)
                        report_field("last_median", want.last_median, got.last_median);
                end
            end
            if (ready_run > 0) begin
                ready_run--;
            end else begin
                m_tready <= !m_tready;
                ready_run = m_tready ? $urandom_range(0, 4)
                          : (($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                         : $urandom_range(1, 10));
            end
        end
    end

    // Stimulus helpers. Readings are given as the net value the block will see.
    task automatic push_tick(input int net, input logic disp_lvl, input logic mode_lvl);
        tick_t t;
        t.raw      = SAMPLE_W'(-net);
        t.disp_lvl = disp_lvl;
        t.mode_lvl = mode_lvl;
        tick_feed.push_back(t);
    endtask

    function automatic int any_net();
        return int'($urandom_range(0, 16777215)) + NET_MIN;
    endfunction

    function automatic int low_net();
        return NET_MIN + int'($urandom_range(0, 4000000));
    endfunction

    function automatic int high_net();
        return ($urandom_range(0, 1) == 0) ? NET_MAX : NET_MAX - int'($urandom_range(0, 400000));
    endfunction

    function automatic logic any_level();
        return logic'($urandom_range(0, 1));
    endfunction

    // Readings during a fill: half of them close to one of the thresholds.
    function automatic int fill_reading();
        int v;
        case ($urandom_range(0, 3))
            0: v = any_net();
            1: v = low_net();
            default: v = int'(thr_reg[$urandom_range(0, NUM_THR-1)])
                         + int'($urandom_range(0, 2000)) - 1000;
        endcase
        return (v > NET_MAX) ? NET_MAX : ((v < NET_MIN) ? NET_MIN : v);
    endfunction

    // Whole groups of readings with dispense mostly held, then a group high
    // enough to stop an automatic fill and with dispense released to stop a
    // manual one.
    task automatic queue_fill_body();
        int groups;
        groups = $urandom_range(0, 3);
        repeat (GROUP_N * groups)
            push_tick(fill_reading(), ($urandom_range(0, 9) == 0) ? RELEASED : PRESSED,
                      any_level());
        repeat (GROUP_N)
            push_tick(high_net(), RELEASED, any_level());
    endtask

    task automatic queue_traffic(input int count);
        int goal, quiet;
        goal = tick_feed.size() + count;
        while (tick_feed.size() < goal) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    repeat ($urandom_range(1, 4)) push_tick(any_net(), any_level(), any_level());
                end
                2, 3, 4: begin
                    // Mode press: held a few ticks, then released long enough to
                    // settle, now and then cut short so that no press registers.
                    repeat ($urandom_range(1, 3)) push_tick(any_net(), RELEASED, PRESSED);
                    quiet = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 11) : 12;
                    repeat (quiet - 1) push_tick(any_net(), RELEASED, RELEASED);
                    if ($urandom_range(0, 2) == 0) begin
                        // The press lands on the tick that starts a fill.
                        push_tick(low_net(), PRESSED, RELEASED);
                        queue_fill_body();
                    end else begin
                        push_tick(any_net(), RELEASED, RELEASED);
                    end
                end
                default: begin
                    push_tick(($urandom_range(0, 4) == 0) ? any_net() : low_net(), PRESSED,
                              any_level());
                    queue_fill_body();
                end
            endcase
        end
    endtask

    // Every item yields one result, so an empty expectation store means idle.
    task automatic wait_drained();
        while (tick_feed.size() != 0 || s_tvalid || due_results.size() != 0)
            @(posedge aclk);
    endtask

    // Writes all three thresholds and a junk write to the spare index,
    // keeping valid high between consecutive writes.
    task automatic write_thresholds(input thr_t t0, input thr_t t1, input thr_t t2);
        logic [CFG_IDX_W-1:0] idx[4];
        thr_t                 val[4];
        idx = '{CFG_THR_MODE0, CFG_THR_MODE1, CFG_THR_MODE2, CFG_SPARE};
        val = '{t0, t1, t2, thr_t'($urandom)};
        for (int i = 0; i < 4; i++) begin
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            cfg_valid <= 1'b1;
            do @(posedge aclk); while (!cfg_ready);
            if (idx[i] < NUM_THR) thr_reg[idx[i]] = val[i];
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed opening in mode 0 with reset thresholds: reading extremes,
        // dispense held above threshold, a fill ending exactly on threshold
        // with mode presses ignored, and a press landing on a start tick.
        push_tick(NET_MIN, RELEASED, RELEASED);
        push_tick(NET_MAX, PRESSED, RELEASED);
        push_tick(0, RELEASED, RELEASED);
        push_tick(-5, PRESSED, RELEASED);
        push_tick(10, PRESSED, PRESSED);
        push_tick(300000, RELEASED, PRESSED);
        push_tick(5, PRESSED, PRESSED);
        push_tick(400000, PRESSED, RELEASED);
        push_tick(220000, PRESSED, RELEASED);
        push_tick(NET_MIN, PRESSED, RELEASED);
        push_tick(0, RELEASED, PRESSED);
        repeat (11) push_tick(1000, RELEASED, RELEASED);
        push_tick(-100, PRESSED, RELEASED);
        repeat (GROUP_N) push_tick(NET_MAX, PRESSED, RELEASED);

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) begin
                wait_drained();
                case (ph)
                    1: write_thresholds(thr_t'(NET_MAX), thr_t'(NET_MIN), THR_MANUAL);
                    2: write_thresholds(thr_t'(any_net()), thr_t'(any_net()),
                                        thr_t'(any_net()));
                    3: write_thresholds(thr_t'(NET_MIN), THR_MANUAL, thr_t'(NET_MAX));
                    default: write_thresholds(thr_t'($urandom_range(0, 300000)),
                                              thr_t'($urandom_range(0, 300000)),
                                              thr_t'($urandom_range(0, 300000)));
                endcase
            end
            queue_traffic(TICKS_PER_PHASE);
        end

        wait_drained();
        // Leave room for any stray result to show up.
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("weigh_fill_controller regression: pass");
        end else begin
            $display("weigh_fill_controller regression: fail");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("weigh_fill_controller regression: fail");
        $finish;
    end

endmodule

// ----- weigh_fill_controller.f -----
hw/rtl/wfc_pkg.sv
hw/rtl/wfc_median.sv
hw/rtl/wfc_ctrl.sv
hw/rtl/weigh_fill_controller.sv
dv/tb_weigh_fill_controller.sv
